@@ sv/srq_pkg.sv @@
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants of the sorted run queue
// Widths, status codes and the beat and cell structs used by every file.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int TASK_ID_BITS = 8;
  localparam int KEY_BITS     = 32;
  localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int READY_BITS   = 6;

  localparam logic       ACT_MOVE = 1'b0;
  localparam logic       ACT_TAKE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                    action;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [KEY_BITS-1:0]     usage_key;
    logic                    clear_usage;
    logic                    current_valid;
    logic [KEY_BITS-1:0]     current_key;
    logic                    at_interrupt;
    logic                    kernel_mode;
  } item_t;

  typedef struct packed {
    logic                    taken_valid;
    logic [TASK_ID_BITS-1:0] taken_id;
    logic [KEY_BITS-1:0]     taken_key;
    logic                    preempt_pending;
    logic                    switch_now;
    logic [READY_BITS-1:0]   ready_count;
    logic [1:0]              status;
  } result_t;

  // One slot of the queue.
  typedef struct packed {
    logic                    valid;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [KEY_BITS-1:0]     key;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    remove;
    logic                    place;
    logic [TASK_ID_BITS-1:0] match_id;
    logic [TASK_ID_BITS-1:0] new_task;
    logic [KEY_BITS-1:0]     new_key;
  } cell_ctl_t;

endpackage

@@ sv/sorted_run_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_run_queue: ready queue of tasks ordered by ascending usage key
// A result is registered at the end of its placement cycle, which finishes
// only when the output register is free.
// A new item is taken only once the last one is placed: the removal cycle
// pulls the entry out of the cell row, the placement cycle places it (the row is the shared resource).
// A result waiting on a stalled output holds the placement cycle, and the
// item input stays stalled until that cycle finishes.
// Reset clears the valid bit of every cell and the count; there is no sweep.
// ----------------------------------------------------------------------------
module sorted_run_queue import srq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PLACE = 1'b1;

  // Control state.
  logic                  state;
  logic [COUNT_BITS-1:0] count;

  // Item held between the removal and the placement cycles.
  logic                    hold_place;
  logic [TASK_ID_BITS-1:0] hold_task;
  logic [KEY_BITS-1:0]     hold_key;
  result_t                 hold_result;

  // Cell row wiring.
  cell_ctl_t ctl;
  entry_t    slots [QUEUE_DEPTH];
  entry_t    lefts [QUEUE_DEPTH];
  entry_t    rights[QUEUE_DEPTH];
  logic      match_chain[QUEUE_DEPTH+1];
  logic      open_chain [QUEUE_DEPTH+1];

  logic                  accept;
  logic                  commit;
  logic                  is_take;
  logic                  empty;
  logic                  found;
  logic                  removed;
  logic [KEY_BITS-1:0]   key_eff;
  logic                  preempt;
  logic [COUNT_BITS-1:0] count_mid;
  logic [COUNT_BITS-1:0] count_next;
  result_t               result_next;
  result_t               result_out;

  assign item_stall = (state == ST_PLACE);
  assign accept     = item_valid && !item_stall;
  // The placement cycle finishes only when the output register is free.
  assign commit     = (state == ST_PLACE) && (!result_valid || !result_stall);

  assign is_take = (item.action == ACT_TAKE);
  assign empty   = (count == '0);
  assign found   = match_chain[QUEUE_DEPTH];
  assign removed = is_take ? !empty : found;
  assign key_eff = item.clear_usage ? '0 : item.usage_key;
  assign preempt = !is_take && item.current_valid && (key_eff < item.current_key);

  assign count_mid  = removed ? count - COUNT_BITS'(1) : count;
  assign count_next = hold_place ? count + COUNT_BITS'(1) : count;

  // The incoming beat drives the removal; the held item drives placement.
  always_comb begin
    ctl.remove   = accept && removed;
    ctl.place    = commit && hold_place;
    ctl.match_id = item.task_id;
    ctl.new_task = hold_task;
    ctl.new_key  = hold_key;
  end

  // A take forces the removal chain on at the head, so every entry shifts.
  assign match_chain[0] = is_take;
  // The head has nothing to its left and always takes the new entry if open.
  assign open_chain[0]  = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '0;
    end else begin : g_body
      assign lefts[i] = slots[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = slots[i+1];
    end

    srq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (lefts[i]),
      .right     (rights[i]),
      .match_in  (match_chain[i]),
      .match_out (match_chain[i+1]),
      .open_in   (open_chain[i]),
      .open_out  (open_chain[i+1]),
      .slot      (slots[i])
    );
  end

  // Result fields known at the removal cycle; the count is filled in later.
  always_comb begin
    result_next             = '0;
    result_next.status      = STATUS_OK;
    if (is_take) begin
      if (empty) begin
        result_next.status = STATUS_EMPTY;
      end else begin
        result_next.taken_valid = 1'b1;
        result_next.taken_id    = slots[0].task_id;
        result_next.taken_key   = slots[0].key;
      end
    end else begin
      result_next.preempt_pending = preempt;
      result_next.switch_now      = preempt && item.at_interrupt && !item.kernel_mode;
      if (!found && (count == COUNT_BITS'(QUEUE_DEPTH))) begin
        result_next.status = STATUS_FULL;
      end
    end
  end

  // The count becomes known in the placement cycle.
  always_comb begin
    result_out             = hold_result;
    result_out.ready_count = READY_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      hold_place   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state      <= ST_PLACE;
        count      <= count_mid;
        // A move is placed unless it was a new task meeting a full queue.
        hold_place <= !is_take && (found || (count != COUNT_BITS'(QUEUE_DEPTH)));
      end else if (commit) begin
        state <= ST_IDLE;
        count <= count_next;
      end

      if (commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_task   <= item.task_id;
      hold_key    <= key_eff;
      hold_result <= result_next;
    end
    if (commit) begin
      result <= result_out;
    end
  end

endmodule

@@ sv/srq_cell.sv @@
// ----------------------------------------------------------------------------
// srq_cell: one slot of the sorted queue
// Holds one entry and trades it with its neighbors on remove and place.
// ----------------------------------------------------------------------------
module srq_cell import srq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    left,
  input  entry_t    right,
  input  logic      match_in,
  output logic      match_out,
  input  logic      open_in,
  output logic      open_out,
  output entry_t    slot
);

  logic self_match;

  // A removal anywhere at or before this slot pulls the right neighbor in.
  assign self_match = slot.valid && (slot.task_id == ctl.match_id);
  assign match_out  = match_in | self_match;

  // The slot opens when it is empty or holds a strictly larger key, so equal
  // keys stay ahead of the new entry.
  assign open_out = !slot.valid || (slot.key > ctl.new_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (ctl.remove && match_out) begin
      slot <= right;
    end else if (ctl.place && open_out) begin
      if (open_in) begin
        slot <= left;
      end else begin
        slot.valid   <= 1'b1;
        slot.task_id <= ctl.new_task;
        slot.key     <= ctl.new_key;
      end
    end
  end

endmodule

@@ dv/srq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srq_checker: scoreboard for the sorted run queue
// Keeps its own copy of the ready queue, predicts one result for every
// accepted item beat and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module srq_checker import srq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      errors,
  output int      pending
);

  // Shadow copy of the queue, slot 0 is the head.
  logic [KEY_BITS-1:0]     shadow_key  [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] shadow_task [QUEUE_DEPTH];
  int                      shadow_len;

  result_t awaited_results[$];
  int      fail_total = 0;

  assign errors = fail_total;
  initial pending = 0;

  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_len; i++) begin
      shadow_key[i]  = shadow_key[i + 1];
      shadow_task[i] = shadow_task[i + 1];
    end
    shadow_len--;
  endfunction

  function automatic result_t next_queue_result(input item_t it);
    result_t                 r;
    logic [KEY_BITS-1:0]     key;
    int                      pos;
    int                      i;
    bit                      found;
    r = '0;
    if (it.action == ACT_TAKE) begin
      if (shadow_len == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.taken_valid = 1'b1;
        r.taken_id    = shadow_task[0];
        r.taken_key   = shadow_key[0];
        drop_slot(0);
      end
    end else begin
      key = it.clear_usage ? '0 : it.usage_key;
      // The preemption check is made even when the insert ends up dropped.
      if (it.current_valid && key < it.current_key) begin
        r.preempt_pending = 1'b1;
        r.switch_now      = it.at_interrupt && !it.kernel_mode;
      end
      found = 1'b0;
      for (i = 0; i < shadow_len && !found; i++) begin
        if (shadow_task[i] == it.task_id) begin
          drop_slot(i);
          found = 1'b1;
        end
      end
      if (!found && shadow_len >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // Equal keys keep arrival order: skip every entry with key <= ours.
        pos = 0;
        while (pos < shadow_len && shadow_key[pos] <= key) pos++;
        for (i = shadow_len; i > pos; i--) begin
          shadow_key[i]  = shadow_key[i - 1];
          shadow_task[i] = shadow_task[i - 1];
        end
        shadow_key[pos]  = key;
        shadow_task[pos] = it.task_id;
        shadow_len++;
      end
    end
    r.ready_count = shadow_len[READY_BITS-1:0];
    return r;
  endfunction

  function automatic int check_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_len = 0;
      awaited_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %p", $time, result);
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          fail_total += check_field("taken_valid", 64'(want.taken_valid),
                                    64'(result.taken_valid));
          fail_total += check_field("taken_id", 64'(want.taken_id), 64'(result.taken_id));
          fail_total += check_field("taken_key", 64'(want.taken_key),
                                    64'(result.taken_key));
          fail_total += check_field("preempt_pending", 64'(want.preempt_pending),
                                    64'(result.preempt_pending));
          fail_total += check_field("switch_now", 64'(want.switch_now),
                                    64'(result.switch_now));
          fail_total += check_field("ready_count", 64'(want.ready_count),
                                    64'(result.ready_count));
          fail_total += check_field("status", 64'(want.status), 64'(result.status));
        end
      end
      if (item_valid && !item_stall) awaited_results.push_back(next_queue_result(item));
    end
    pending <= awaited_results.size();
  end

endmodule

@@ dv/tb_sorted_run_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_run_queue: stimulus and verdict for the sorted run queue
// A directed opening covers empty takes, key extremes, the clear flag, the
// preempt and switch flags, equal-key ordering and re-moves; random phases
// then fill, drain and churn the queue under random sender gaps and
// receiver stalls. All checking lives in srq_checker.
// ----------------------------------------------------------------------------
module tb_sorted_run_queue;
  import srq_pkg::*;

  localparam int RANDOM_BEATS = 950;

  // Flavors of random traffic; each phase of the random part picks one.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_REUSE} traffic_mix_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      errors;
  int      pending;

  // Sender pacing state: beats left in the current burst.
  int burst_left = 0;

  always #5 clk = ~clk;

  sorted_run_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  srq_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  // Receiver backpressure. Every so often a new mode is chosen: no stalls at
  // all, light random stalls, heavy random stalls, or long alternating runs
  // of stall and release. Modes last long enough to matter but change often
  // enough that stalls land on both the removal and the placement cycle of an item.
  int  stall_mode = 0;
  int  stall_span = 0;
  int  stall_run  = 0;
  logic stall_level = 1'b0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 4) != 0);
      default: begin
        if (stall_run == 0) begin
          stall_run   = $urandom_range(1, 25);
          stall_level = ~stall_level;
        end
        stall_run--;
        result_stall <= stall_level;
      end
    endcase
  end

  // Hard stop, far beyond the slowest legal run (a removal and a placement
  // step per item plus the longest receiver stall and sender gap on every
  // beat).
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Presents one item beat and returns in the time step of the edge that
  // took it, or after the gap that follows it. Between bursts the valid drops for
  // a random gap; within a burst valid stays high and only the payload changes.
  task automatic send_beat(input item_t it);
    int gap;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds the sender off until every predicted result has been checked. The
  // first edge lets the checker count the last accepted beat.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic item_t move_item(input logic [TASK_ID_BITS-1:0] id,
                                      input logic [KEY_BITS-1:0] key, input logic clr,
                                      input logic cur_valid, input logic [KEY_BITS-1:0] cur_key,
                                      input logic irq, input logic kern);
    item_t it;
    it.action        = ACT_MOVE;
    it.task_id       = id;
    it.usage_key     = key;
    it.clear_usage   = clr;
    it.current_valid = cur_valid;
    it.current_key   = cur_key;
    it.at_interrupt  = irq;
    it.kernel_mode   = kern;
    return it;
  endfunction

  function automatic item_t take_item();
    item_t it;
    it        = '0;
    it.action = ACT_TAKE;
    return it;
  endfunction

  // Keys lean toward the extremes and a narrow band of small values, so that
  // equal keys and equal-to-current comparisons come up often.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Take beats carry random move fields too; the block must ignore them.
  function automatic item_t random_item(input int take_pct, input int id_top);
    item_t it;
    it.action        = ($urandom_range(0, 99) < take_pct) ? ACT_TAKE : ACT_MOVE;
    it.task_id       = TASK_ID_BITS'($urandom_range(0, id_top));
    it.usage_key     = pick_key();
    it.clear_usage   = ($urandom_range(0, 7) == 0);
    it.current_valid = ($urandom_range(0, 3) != 0);
    it.current_key   = pick_key();
    it.at_interrupt  = 1'($urandom_range(0, 1));
    it.kernel_mode   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin
    traffic_mix_t mix;
    int           rand_sent;
    int           phase_len;
    int           take_pct;
    int           id_top;
    int           k;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening.
    send_beat(take_item());                                    // take from empty
    send_beat(move_item(8'd0,   '0,   1'b0, 1'b1, '0, 1'b1, 1'b0)); // 0 < 0 is no preempt
    send_beat(move_item(8'd255, '1,   1'b0, 1'b1, '1, 1'b1, 1'b0)); // top key, equal to current
    send_beat(move_item(8'd7,   32'd100, 1'b0, 1'b1, 32'd101, 1'b1, 1'b0)); // preempt and switch
    send_beat(move_item(8'd8,   32'd100, 1'b0, 1'b1, 32'd200, 1'b1, 1'b1)); // kernel: no switch
    send_beat(move_item(8'd9,   32'd100, 1'b0, 1'b0, '1, 1'b1, 1'b0)); // nothing running
    send_beat(move_item(8'd10,  '1,   1'b1, 1'b1, 32'd1, 1'b1, 1'b0)); // clear flag zeroes key
    send_beat(move_item(8'd7,   32'd5,   1'b0, 1'b1, 32'd5, 1'b0, 1'b0)); // re-move queued task
    send_beat(move_item(8'd255, '0,   1'b0, 1'b1, '1, 1'b0, 1'b1)); // moves behind equal zeros
    send_beat(move_item(8'd0,   32'd50,  1'b0, 1'b1, '1, 1'b1, 1'b0)); // head moves back
    // Six tasks are queued; drain them all and take once more from empty.
    repeat (7) send_beat(take_item());
    send_beat(move_item('1, '1, 1'b0, 1'b1, '1, 1'b1, 1'b1));   // all ones
    send_beat(move_item('1, '1, 1'b1, 1'b1, '1, 1'b1, 1'b0));   // cleared against top key
    send_beat(take_item());
    send_beat(take_item());

    // Let the opening fully retire before random traffic starts.
    wait_drained();

    // Random part. The first phase is always a fill so the queue reaches its
    // depth early and the full-queue drop is exercised; afterwards phases mix
    // draining, balanced churn and re-moves among a handful of ids.
    rand_sent = 0;
    mix       = MIX_FILL;
    while (rand_sent < RANDOM_BEATS) begin
      case (mix)
        MIX_FILL:  begin take_pct = 10; id_top = 255; end
        MIX_DRAIN: begin take_pct = 75; id_top = 255; end
        MIX_EVEN:  begin take_pct = 45; id_top = 40;  end
        default:   begin take_pct = 30; id_top = 7;   end
      endcase
      phase_len = $urandom_range(40, 120);
      for (k = 0; k < phase_len && rand_sent < RANDOM_BEATS; k++) begin
        send_beat(random_item(take_pct, id_top));
        rand_sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
      mix = traffic_mix_t'($urandom_range(0, 3));
    end

    // Wind down: every result back, then an idle stretch to catch strays.
    wait_drained();
    repeat (10) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
